// ===== hdl/tcw_pkg.sv =====
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_HEX  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	localparam logic [7:0]  ATTR_RESET   = 8'h07;
	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	// space character with light-gray attribute, used to blank a scrolled-in row
	localparam logic [15:0] BLANK_CELL   = 16'h0720;

	// Result handed from the engine to the output register
	typedef struct packed {
		logic        valid;
		logic [15:0] data;
		logic [10:0] cursor;
		logic        scrolled;
	} res_t;

	// Upper-case hex glyph of one nibble
	function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
		logic [7:0] g;
		if (nib < 4'd10) begin
			g = 8'h30 + {4'h0, nib};
		end else begin
			g = 8'h37 + {4'h0, nib};
		end
		return g;
	endfunction

endpackage

// ===== hdl/tcw_screen_ram.sv =====
// Character cell store: one write port, one read port, registered read data.
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	// write first in array order; a read of the same address returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/tcw_engine.sv =====
// Console sequencer: clear pass, put/hex/read items, cursor and row scroll.
module tcw_engine #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25,
	parameter int CELLS          = SCREEN_COLUMNS * SCREEN_ROWS,
	parameter int AW             = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        opcode,
	input  logic [7:0]        char_code,
	input  logic [31:0]       hex_value,
	input  logic [10:0]       cell_index,
	input  logic [7:0]        attr,
	// result toward the output register
	output tcw_pkg::res_t     res,
	input  logic              res_take,
	// cell store
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [15:0]       mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	input  logic [15:0]       mem_rdata
);

	localparam int CLW       = $clog2(SCREEN_COLUMNS);
	localparam int MOVE      = CELLS - SCREEN_COLUMNS;
	localparam int LAST_ROW  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_PUT    = 7'b0000100,
		S_READ   = 7'b0001000,
		S_SCROLL = 7'b0010000,
		S_DRAIN  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     cursor_q;
	logic [CLW-1:0]    col_q;
	tcw_pkg::opcode_t  op_q;
	logic [7:0]        ch_q;
	logic [31:0]       hex_q;
	logic [2:0]        dig_q;
	logic              rolled_q;
	logic              inrange_q;
	logic              last_q;
	logic [15:0]       data_q;
	logic [AW-1:0]     sc_q;
	logic              mv_s1;
	logic              blank_s1;
	logic [AW-1:0]     mvaddr_s1;

	logic              accept;
	logic [7:0]        cur_ch;
	logic              is_nl;
	logic [AW:0]       nxt;
	logic [CLW-1:0]    col_nxt;
	logic              scroll_hit;
	logic              last_dig;
	logic [31:0]       idx_ext;
	logic [31:0]       cur_ext;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign idx_ext    = 32'(cell_index);

	// character of the current put step
	assign cur_ch = (op_q == tcw_pkg::OP_PUT) ? ch_q : tcw_pkg::hex_glyph(hex_q[31:28]);
	assign is_nl  = (op_q == tcw_pkg::OP_PUT) && (ch_q == tcw_pkg::NEWLINE_CODE);

	// cursor advance; column tracked alongside to avoid a modulo
	always_comb begin
		if (is_nl) begin
			nxt     = {1'b0, cursor_q} - (AW+1)'(col_q) + (AW+1)'(SCREEN_COLUMNS);
			col_nxt = '0;
		end else begin
			nxt     = {1'b0, cursor_q} + (AW+1)'(1);
			col_nxt = (col_q == CLW'(SCREEN_COLUMNS - 1)) ? '0 : col_q + CLW'(1);
		end
	end
	assign scroll_hit = (nxt >= (AW+1)'(CELLS));
	assign last_dig   = (op_q != tcw_pkg::OP_HEX) || (dig_q == 3'd7);

	// cell store access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_q;
		mem_wdata = {attr, cur_ch};
		mem_raddr = idx_ext[AW-1:0];
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == S_PUT) begin
			mem_we = !is_nl;
		end else if (mv_s1) begin
			mem_we    = 1'b1;
			mem_waddr = mvaddr_s1;
			mem_wdata = blank_s1 ? tcw_pkg::BLANK_CELL : mem_rdata;
		end
		if (state_q == S_SCROLL) begin
			mem_raddr = sc_q + AW'(SCREEN_COLUMNS);
		end
	end

	// result
	assign cur_ext      = 32'(cursor_q);
	assign res.valid    = (state_q == S_DONE);
	assign res.data     = data_q;
	assign res.cursor   = cur_ext[10:0];
	assign res.scrolled = rolled_q;

	// scroll move pipeline: read at sc+C, write at sc in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= (state_q == S_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		mvaddr_s1 <= sc_q;
		blank_s1  <= (32'(sc_q) >= MOVE);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cursor_q  <= '0;
			col_q     <= '0;
			op_q      <= tcw_pkg::OP_NONE;
			dig_q     <= '0;
			rolled_q  <= 1'b0;
			inrange_q <= 1'b0;
			last_q    <= 1'b1;
			sc_q      <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q      <= tcw_pkg::opcode_t'(opcode);
						dig_q     <= '0;
						rolled_q  <= 1'b0;
						inrange_q <= (idx_ext < CELLS);
						case (tcw_pkg::opcode_t'(opcode))
							tcw_pkg::OP_PUT, tcw_pkg::OP_HEX: state_q <= S_PUT;
							tcw_pkg::OP_READ:                 state_q <= S_READ;
							default:                          state_q <= S_DONE;
						endcase
					end
				end
				S_PUT: begin
					if (!last_dig) begin
						dig_q <= dig_q + 3'd1;
					end
					last_q <= last_dig;
					if (scroll_hit) begin
						cursor_q <= AW'(LAST_ROW);
						col_q    <= '0;
						rolled_q <= 1'b1;
						sc_q     <= '0;
						state_q  <= S_SCROLL;
					end else begin
						cursor_q <= nxt[AW-1:0];
						col_q    <= col_nxt;
						if (last_dig) begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCROLL: begin
					sc_q <= sc_q + AW'(1);
					if (sc_q == AW'(CELLS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= last_q ? S_DONE : S_PUT;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= char_code;
			hex_q  <= hex_value;
			data_q <= '0;
		end else if (state_q == S_PUT && !last_dig) begin
			hex_q <= {hex_q[27:0], 4'h0};
		end else if (state_q == S_READ) begin
			data_q <= inrange_q ? mem_rdata : '0;
		end
	end

endmodule

// ===== hdl/text_console_writer.sv =====
// Text console writer top level: attribute register, engine, cell store, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  item     | item_valid / item_stall    | opcode, char_code, hex_value, cell_index
//  result   | result_valid / result_stall| cell_data, cursor_position, scrolled
//  attr     | attr_valid / attr_ready    | text_attribute
//
//  The unused opcode goes straight to its result; a hex item writes its eight digit glyphs,
//  most significant first. During a scroll the single-port-pair cell store moves one cell
//  per cycle. After reset the store is cleared while item_stall stays high; attribute
//  writes are taken at any time. A stalled result waits in the output register while the
//  next item is accepted.
module text_console_writer #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [31:0] hex_value,
	input  logic [10:0] cell_index,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] cell_data,
	output logic [10:0] cursor_position,
	output logic        scrolled,
	input  logic        attr_valid,
	output logic        attr_ready,
	input  logic [7:0]  text_attribute
);

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [7:0]     attr_q;
	tcw_pkg::res_t  res;
	logic           res_take;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [15:0]    mem_wdata;
	logic [AW-1:0]  mem_raddr;
	logic [15:0]    mem_rdata;

	// attribute register, always writable
	assign attr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (attr_valid && attr_ready) begin
			attr_q <= text_attribute;
		end
	end

	tcw_engine #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS),
		.CELLS          (CELLS),
		.AW             (AW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.char_code  (char_code),
		.hex_value  (hex_value),
		.cell_index (cell_index),
		.attr       (attr_q),
		.res        (res),
		.res_take   (res_take),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_take = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res.valid && res_take) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			cell_data       <= res.data;
			cursor_position <= res.cursor;
			scrolled        <= res.scrolled;
		end
	end

endmodule

// ===== hdl/tcw_checker.sv =====
// Port-level checks of the text console writer and their binding.
module tcw_checker #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] cell_data,
	input logic [10:0] cursor_position,
	input logic        scrolled
);

	localparam int CELLS    = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int LAST_ROW = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
	localparam bit NARROW   = (CELLS <= 2048);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			$stable(cell_data) && $stable(cursor_position) && $stable(scrolled))
		else $error("result payload changed while stalled");

	// one item at a time: the engine is busy right after a transaction
	a_item_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted on back-to-back cycles");

	// cursor on the screen whenever a result is offered (screens of up to 2048 cells)
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !NARROW || (32'(cursor_position) < CELLS))
		else $error("cursor beyond last cell");

	// after a scroll the cursor sits in the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && scrolled |-> !NARROW || (32'(cursor_position) >= LAST_ROW))
		else $error("cursor not in bottom row after scroll");

endmodule

bind text_console_writer tcw_checker #(
	.SCREEN_COLUMNS (SCREEN_COLUMNS),
	.SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item_valid),
	.item_stall      (item_stall),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.cell_data       (cell_data),
	.cursor_position (cursor_position),
	.scrolled        (scrolled)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text console writer against a cell-store predictor.
module tb;

	localparam int COLS       = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLS * ROWS;
	// Slowest quiet stretch: store clear or one scroll, a long receiver hold and random stalls
	// on top; taken several times over.
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [15:0] data;
		logic [10:0] cursor;
		logic        scrolled;
	} console_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  opcode = tcw_pkg::OP_NONE;
	logic [7:0]  char_code = '0;
	logic [31:0] hex_value = '0;
	logic [10:0] cell_index = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] cell_data;
	logic [10:0] cursor_position;
	logic        scrolled;
	logic        attr_valid = 1'b0;
	logic        attr_ready;
	logic [7:0]  text_attribute = tcw_pkg::ATTR_RESET;

	// Predicted console state
	logic [15:0] screen_model [CELL_COUNT];
	int          cursor_model = 0;
	logic [7:0]  attr_model = tcw_pkg::ATTR_RESET;

	console_out_t expected_results [$];
	int           error_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	logic         hold_start = 1'b0;

	text_console_writer #(
		.SCREEN_COLUMNS (COLS),
		.SCREEN_ROWS    (ROWS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.opcode          (opcode),
		.char_code       (char_code),
		.hex_value       (hex_value),
		.cell_index      (cell_index),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.cell_data       (cell_data),
		.cursor_position (cursor_position),
		.scrolled        (scrolled),
		.attr_valid      (attr_valid),
		.attr_ready      (attr_ready),
		.text_attribute  (text_attribute)
	);

	always #10 clk = ~clk;

	// One character into the predicted screen; returns 1 when it scrolled
	function automatic bit console_put(logic [7:0] ch);
		bit rolled;
		rolled = 1'b0;
		if (ch == tcw_pkg::NEWLINE_CODE) begin
			cursor_model += COLS - (cursor_model % COLS);
		end else begin
			screen_model[cursor_model] = {attr_model, ch};
			cursor_model++;
		end
		if (cursor_model >= CELL_COUNT) begin
			for (int i = 0; i < CELL_COUNT - COLS; i++)
				screen_model[i] = screen_model[i + COLS];
			for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
				screen_model[i] = tcw_pkg::BLANK_CELL;
			cursor_model -= COLS;
			rolled = 1'b1;
		end
		return rolled;
	endfunction

	// Expected result of one item; updates the predicted state
	function automatic console_out_t console_apply(tcw_pkg::opcode_t op, logic [7:0] ch,
			logic [31:0] word, logic [10:0] idx);
		console_out_t r;
		logic [3:0]   nib;
		r.data = '0;
		r.scrolled = 1'b0;
		case (op)
			tcw_pkg::OP_PUT: begin
				r.scrolled = console_put(ch);
			end
			tcw_pkg::OP_HEX: begin
				for (int n = 7; n >= 0; n--) begin
					nib = word[n*4 +: 4];
					if (console_put((nib < 4'd10) ? "0" + nib : "A" + nib - 8'd10))
						r.scrolled = 1'b1;
				end
			end
			tcw_pkg::OP_READ: begin
				if (idx < CELL_COUNT)
					r.data = screen_model[idx];
			end
			default: ;
		endcase
		r.cursor = cursor_model[10:0];
		return r;
	endfunction

	// Sender: optional gap, then hold the item until the block takes it
	task automatic send_item(tcw_pkg::opcode_t op, logic [7:0] ch, logic [31:0] word,
			logic [10:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		hex_value  <= word;
		cell_index <= idx;
		do @(posedge clk); while (item_stall);
		expected_results.push_back(console_apply(op, ch, word, idx));
	endtask

	// Drop valid and wait for every expected result to come back
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attr(logic [7:0] value);
		attr_valid     <= 1'b1;
		text_attribute <= value;
		do @(posedge clk); while (!attr_ready);
		attr_valid <= 1'b0;
		attr_model = value;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// Random item, biased toward text with newlines and reads near written cells
	task automatic send_random_item();
		int               pick;
		int               row_start;
		tcw_pkg::opcode_t op;
		logic [7:0]       ch;
		logic [31:0]      word;
		logic [10:0]      idx;
		pick = $urandom_range(99);
		ch   = 8'($urandom_range(255));
		word = $urandom;
		idx  = 11'($urandom_range(2047));
		if (pick < 50) begin
			op = tcw_pkg::OP_PUT;
			if ($urandom_range(7) == 0)
				ch = tcw_pkg::NEWLINE_CODE;
		end else if (pick < 68) begin
			op = tcw_pkg::OP_HEX;
		end else if (pick < 95) begin
			op = tcw_pkg::OP_READ;
			row_start = cursor_model - (cursor_model % COLS);
			case ($urandom_range(3))
				0: idx = 11'($urandom_range(CELL_COUNT - 1));
				1: idx = 11'(row_start + $urandom_range(COLS - 1));
				2: idx = 11'(CELL_COUNT - COLS + $urandom_range(COLS - 1));
				default: ;
			endcase
		end else begin
			op = tcw_pkg::OP_NONE;
		end
		send_item(op, ch, word, idx);
	endtask

	// Cleared store and out-of-range reads right after reset
	task automatic test_reset_state();
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'd0);
		send_item(tcw_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF, 11'd1999);
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'd2000);
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'h7FF);
	endtask

	// Plain puts, hex words, unused opcode, attribute extremes
	task automatic test_put_and_hex();
		send_item(tcw_pkg::OP_PUT, 8'h41, 32'h0, 11'd0);
		send_item(tcw_pkg::OP_PUT, 8'h00, 32'hFFFF_FFFF, 11'h7FF);
		wait_idle();
		write_attr(8'hFF);
		send_item(tcw_pkg::OP_PUT, 8'hFF, 32'h0, 11'd0);
		send_item(tcw_pkg::OP_HEX, 8'h00, 32'h89AB_CDEF, 11'd0);
		wait_idle();
		write_attr(8'h00);
		send_item(tcw_pkg::OP_HEX, 8'h00, 32'h0123_4567, 11'd0);
		send_item(tcw_pkg::OP_NONE, 8'hFF, 32'hFFFF_FFFF, 11'h7FF);
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'd5);
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'd15);
	endtask

	// Newlines down to the bottom row, a newline there scrolls; the new row is blank
	task automatic test_scroll();
		wait_idle();
		write_attr(8'h5A);
		while (cursor_model < CELL_COUNT - COLS)
			send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 32'h0, 11'd0);
		send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 32'h0, 11'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'(CELL_COUNT - COLS));
		send_item(tcw_pkg::OP_READ, 8'h00, 32'h0, 11'(CELL_COUNT - 1));
	endtask

	// Receiver holds off for a long stretch while items keep coming
	task automatic test_pressure();
		wait_idle();
		set_idling(0, 0);
		hold_start <= 1'b1;
		repeat (30) send_random_item();
	endtask

	task automatic test_random(int count, int send_pct, int recv_pct);
		set_idling(send_pct, recv_pct);
		repeat (count) send_random_item();
	endtask

	// Receiver stall: random, or one long hold counted here
	int   hold_left = 0;
	logic hold_taken = 1'b0;
	always @(posedge clk) begin
		if (hold_start && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Result checker
	console_out_t want;
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result data=%h cursor=%0d scrolled=%b",
					$time, cell_data, cursor_position, scrolled);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (cell_data !== want.data) begin
					$display("%0t: cell_data expected %h actual %h", $time, want.data, cell_data);
					error_count++;
				end
				if (cursor_position !== want.cursor) begin
					$display("%0t: cursor_position expected %0d actual %0d",
						$time, want.cursor, cursor_position);
					error_count++;
				end
				if (scrolled !== want.scrolled) begin
					$display("%0t: scrolled expected %b actual %b", $time, want.scrolled, scrolled);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(attr_valid && attr_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_put_and_hex();
		test_scroll();
		test_pressure();

		wait_idle();
		write_attr(8'($urandom_range(255)));
		test_random(600, 17, 75);
		wait_idle();
		write_attr(8'hFF);
		test_random(600, 75, 17);
		wait_idle();
		write_attr(8'($urandom_range(255)));
		test_random(300, 0, 0);
		wait_idle();
		write_attr(tcw_pkg::ATTR_RESET);
		test_random(290, 0, 0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
